[hw/rtl/carpi_pkg.sv]
// Shared types and constants for the cascaded angle/rate PI unit.
`default_nettype none

package carpi_pkg;

   // Field widths fixed by the register and stream layout.
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned GAIN_W  = 31;
   localparam int unsigned INDEX_W = 3;

   // Register indexes of the configuration channel.
   localparam logic [INDEX_W-1:0] CSR_COMMAND_SCALE   = 3'd0;
   localparam logic [INDEX_W-1:0] CSR_RATE_LIMIT      = 3'd1;
   localparam logic [INDEX_W-1:0] CSR_ANGLE_KP        = 3'd2;
   localparam logic [INDEX_W-1:0] CSR_ANGLE_KI        = 3'd3;
   localparam logic [INDEX_W-1:0] CSR_ANGLE_INT_LIMIT = 3'd4;
   localparam logic [INDEX_W-1:0] CSR_RATE_KP         = 3'd5;
   localparam logic [INDEX_W-1:0] CSR_RATE_KI         = 3'd6;
   localparam logic [INDEX_W-1:0] CSR_RATE_INT_LIMIT  = 3'd7;

   // Register values after reset.
   localparam logic [GAIN_W-1:0] RST_COMMAND_SCALE   = 31'd0;
   localparam logic [GAIN_W-1:0] RST_RATE_LIMIT      = 31'h7FFF_FFFF;
   localparam logic [GAIN_W-1:0] RST_ANGLE_KP        = 31'd153;
   localparam logic [GAIN_W-1:0] RST_ANGLE_KI        = 31'd0;
   localparam logic [GAIN_W-1:0] RST_ANGLE_INT_LIMIT = 31'd7680;
   localparam logic [GAIN_W-1:0] RST_RATE_KP         = 31'd512;
   localparam logic [GAIN_W-1:0] RST_RATE_KI         = 31'd0;
   localparam logic [GAIN_W-1:0] RST_RATE_INT_LIMIT  = 31'd7680;

   // Sequencer steps, one-hot.
   typedef enum logic [12:0] {
      ST_IDLE    = 13'b0_0000_0000_0001,
      ST_MUL_CMD = 13'b0_0000_0000_0010,
      ST_WAIT    = 13'b0_0000_0000_0100,
      ST_ERR     = 13'b0_0000_0000_1000,
      ST_MUL_AKI = 13'b0_0000_0001_0000,
      ST_MUL_AKP = 13'b0_0000_0010_0000,
      ST_INT_A   = 13'b0_0000_0100_0000,
      ST_TGT     = 13'b0_0000_1000_0000,
      ST_RERR    = 13'b0_0001_0000_0000,
      ST_MUL_RKI = 13'b0_0010_0000_0000,
      ST_MUL_RKP = 13'b0_0100_0000_0000,
      ST_INT_R   = 13'b0_1000_0000_0000,
      ST_DRV     = 13'b1_0000_0000_0000
   } state_type;

   // Operation of the add and clamp unit.
   typedef struct packed {
      logic sub;   // x - y instead of x + y
      logic sat;   // clamp to the 32-bit range instead of +/-limit
   } alu_op_type;

endpackage

`default_nettype wire

[hw/rtl/carpi_mul.sv]
// Shared two-stage fixed-point multiplier with floor shift and 32-bit saturation.
`default_nettype none

module carpi_mul #(
   parameter int unsigned FRACTION_BITS = 8
) (
   input  wire logic                                    clock,
   input  wire logic signed [carpi_pkg::WORD_W-1:0]     a,
   input  wire logic        [carpi_pkg::GAIN_W-1:0]     b,
   output logic      signed [carpi_pkg::WORD_W-1:0]     q
);

   localparam int unsigned PROD_W = carpi_pkg::WORD_W + carpi_pkg::GAIN_W;

   logic signed [2*carpi_pkg::WORD_W-1:0] prod_full;
   logic signed [PROD_W-1:0]              prod_in;
   logic signed [PROD_W-1:0]              prod_ff;
   logic signed [PROD_W-1:0]              shifted;
   logic                                  over_hi;
   logic                                  over_lo;
   logic signed [carpi_pkg::WORD_W-1:0]   q_in;
   logic signed [carpi_pkg::WORD_W-1:0]   q_ff;

   // Stage one: signed times non-negative gain; the product fits in PROD_W bits.
   assign prod_full = a * $signed({1'b0, b});
   assign prod_in   = prod_full[PROD_W-1:0];

   // Stage two: arithmetic shift is the floor division, then saturate.
   assign shifted = prod_ff >>> FRACTION_BITS;
   assign over_hi = !shifted[PROD_W-1] && (|shifted[PROD_W-2:carpi_pkg::WORD_W-1]);
   assign over_lo = shifted[PROD_W-1] && !(&shifted[PROD_W-2:carpi_pkg::WORD_W-1]);

   always_comb begin
      if (over_hi) begin
         q_in = {1'b0, {(carpi_pkg::WORD_W-1){1'b1}}};
      end else if (over_lo) begin
         q_in = {1'b1, {(carpi_pkg::WORD_W-1){1'b0}}};
      end else begin
         q_in = shifted[carpi_pkg::WORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      q_ff    <= q_in;
   end

   assign q = q_ff;

endmodule

`default_nettype wire

[hw/rtl/carpi_alu.sv]
// Shared add/subtract unit with symmetric clamp or 32-bit saturation.
`default_nettype none

module carpi_alu (
   input  wire logic signed [carpi_pkg::WORD_W-1:0] x,
   input  wire logic signed [carpi_pkg::WORD_W-1:0] y,
   input  wire carpi_pkg::alu_op_type               op,
   input  wire logic        [carpi_pkg::GAIN_W-1:0] limit,
   output logic      signed [carpi_pkg::WORD_W-1:0] result
);

   localparam int unsigned SUM_W = carpi_pkg::WORD_W + 1;

   logic signed [SUM_W-1:0] x_ext;
   logic signed [SUM_W-1:0] y_ext;
   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] bound_hi;
   logic signed [SUM_W-1:0] bound_lo;

   // The sum or difference of two 32-bit values always fits in 33 bits.
   assign x_ext = {x[carpi_pkg::WORD_W-1], x};
   assign y_ext = {y[carpi_pkg::WORD_W-1], y};
   assign sum   = op.sub ? (x_ext - y_ext) : (x_ext + y_ext);

   // Saturation has an asymmetric lower bound; the clamp is symmetric.
   always_comb begin
      if (op.sat) begin
         bound_hi = {2'b00, {(carpi_pkg::WORD_W-1){1'b1}}};
         bound_lo = {2'b11, {(carpi_pkg::WORD_W-1){1'b0}}};
      end else begin
         bound_hi = {2'b00, limit};
         bound_lo = -{2'b00, limit};
      end
   end

   always_comb begin
      if (sum > bound_hi) begin
         result = bound_hi[carpi_pkg::WORD_W-1:0];
      end else if (sum < bound_lo) begin
         result = bound_lo[carpi_pkg::WORD_W-1:0];
      end else begin
         result = sum[carpi_pkg::WORD_W-1:0];
      end
   end

endmodule

`default_nettype wire

[hw/rtl/carpi_ctrl.sv]
// Step sequencer for one control tick of the cascaded PI unit.
`default_nettype none

module carpi_ctrl #(
   parameter bit RATE_ONLY_AXIS = 1'b0
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 out_free,
   output carpi_pkg::state_type      state
);

   carpi_pkg::state_type state_ff;
   carpi_pkg::state_type state_in;

   // Fixed walk through the steps; the last one waits for the output register.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         carpi_pkg::ST_IDLE: begin
            if (start) state_in = carpi_pkg::ST_MUL_CMD;
         end
         carpi_pkg::ST_MUL_CMD: state_in = carpi_pkg::ST_WAIT;
         carpi_pkg::ST_WAIT:    state_in = carpi_pkg::ST_ERR;
         carpi_pkg::ST_ERR: begin
            state_in = RATE_ONLY_AXIS ? carpi_pkg::ST_MUL_RKI : carpi_pkg::ST_MUL_AKI;
         end
         carpi_pkg::ST_MUL_AKI: state_in = carpi_pkg::ST_MUL_AKP;
         carpi_pkg::ST_MUL_AKP: state_in = carpi_pkg::ST_INT_A;
         carpi_pkg::ST_INT_A:   state_in = carpi_pkg::ST_TGT;
         carpi_pkg::ST_TGT:     state_in = carpi_pkg::ST_RERR;
         carpi_pkg::ST_RERR:    state_in = carpi_pkg::ST_MUL_RKI;
         carpi_pkg::ST_MUL_RKI: state_in = carpi_pkg::ST_MUL_RKP;
         carpi_pkg::ST_MUL_RKP: state_in = carpi_pkg::ST_INT_R;
         carpi_pkg::ST_INT_R:   state_in = carpi_pkg::ST_DRV;
         carpi_pkg::ST_DRV: begin
            if (out_free) state_in = carpi_pkg::ST_IDLE;
         end
         default: state_in = carpi_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= carpi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

`default_nettype wire

[hw/rtl/cascaded_angle_rate_pi_unit.sv]
// Top level of the cascaded angle/rate PI unit: registers, datapath and stream ports.
`default_nettype none

// One beat on the request side runs one control tick and yields one drive beat.
// A tick is a fixed step sequence around one shared two-stage multiplier and one
// add/clamp unit, so the unit takes a new request only once a tick has run back
// to the idle step; when RATE_ONLY_AXIS is set the angle steps are skipped. The
// two register stages of the multiplier between dependent products set the
// length of the sequence. The finished drive sits in an output register, so a
// new request is taken while it waits; the unit stalls only when a second drive
// is ready before the first one has been taken. Configuration writes are always
// accepted and should be made while no tick is in progress.
module cascaded_angle_rate_pi_unit #(
   parameter int unsigned FRACTION_BITS  = 8,
   parameter bit          RATE_ONLY_AXIS = 1'b0
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,   // stick_command, measured_angle, measured_rate
   // Result stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // drive
   // Configuration write channel.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [30:0] csr_wdata
);

   localparam int unsigned W = carpi_pkg::WORD_W;
   localparam int unsigned G = carpi_pkg::GAIN_W;

   // Configuration registers.
   logic [G-1:0] command_scale_ff;
   logic [G-1:0] rate_limit_ff;
   logic [G-1:0] angle_kp_ff;
   logic [G-1:0] angle_ki_ff;
   logic [G-1:0] angle_int_limit_ff;
   logic [G-1:0] rate_kp_ff;
   logic [G-1:0] rate_ki_ff;
   logic [G-1:0] rate_int_limit_ff;

   // Latched request fields and working state.
   logic signed [W-1:0] stick_ff;
   logic signed [W-1:0] angle_ff;
   logic signed [W-1:0] rate_ff;
   logic signed [W-1:0] err_ff;
   logic signed [W-1:0] err_in;
   logic signed [W-1:0] angle_int_ff;
   logic signed [W-1:0] angle_int_in;
   logic signed [W-1:0] rate_int_ff;
   logic signed [W-1:0] rate_int_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [W-1:0]        rsp_data_ff;
   logic [W-1:0]        rsp_data_in;

   carpi_pkg::state_type   state;
   carpi_pkg::alu_op_type  alu_op;
   logic signed [W-1:0]    mul_a;
   logic        [G-1:0]    mul_b;
   logic signed [W-1:0]    mul_q;
   logic signed [W-1:0]    alu_x;
   logic signed [W-1:0]    alu_y;
   logic        [G-1:0]    alu_limit;
   logic signed [W-1:0]    alu_res;
   logic                   req_beat;
   logic                   out_free;

   assign req_tready = (state == carpi_pkg::ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   carpi_ctrl #(
      .RATE_ONLY_AXIS(RATE_ONLY_AXIS)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (req_beat),
      .out_free(out_free),
      .state   (state)
   );

   // Multiplier operands; the drive gain stays selected while the last step waits.
   always_comb begin
      mul_a = err_ff;
      mul_b = rate_kp_ff;
      case (state)
         carpi_pkg::ST_MUL_CMD: begin
            mul_a = stick_ff;
            mul_b = command_scale_ff;
         end
         carpi_pkg::ST_MUL_AKI: mul_b = angle_ki_ff;
         carpi_pkg::ST_MUL_AKP: mul_b = angle_kp_ff;
         carpi_pkg::ST_MUL_RKI: mul_b = rate_ki_ff;
         default:               mul_b = rate_kp_ff;
      endcase
   end

   carpi_mul #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_mul (
      .clock(clock),
      .a    (mul_a),
      .b    (mul_b),
      .q    (mul_q)
   );

   // Add/clamp operands for each step that uses the unit.
   always_comb begin
      alu_x     = mul_q;
      alu_y     = rate_ff;
      alu_op    = '{sub: 1'b1, sat: 1'b1};
      alu_limit = rate_limit_ff;
      case (state)
         carpi_pkg::ST_ERR: begin
            alu_y = RATE_ONLY_AXIS ? rate_ff : angle_ff;
         end
         carpi_pkg::ST_INT_A: begin
            alu_x     = angle_int_ff;
            alu_y     = mul_q;
            alu_op    = '{sub: 1'b0, sat: 1'b0};
            alu_limit = angle_int_limit_ff;
         end
         carpi_pkg::ST_TGT: begin
            alu_x     = angle_int_ff;
            alu_y     = mul_q;
            alu_op    = '{sub: 1'b0, sat: 1'b0};
            alu_limit = rate_limit_ff;
         end
         carpi_pkg::ST_RERR: begin
            alu_x = err_ff;
         end
         carpi_pkg::ST_INT_R: begin
            alu_x     = rate_int_ff;
            alu_y     = mul_q;
            alu_op    = '{sub: 1'b0, sat: 1'b0};
            alu_limit = rate_int_limit_ff;
         end
         carpi_pkg::ST_DRV: begin
            alu_x  = rate_int_ff;
            alu_y  = mul_q;
            alu_op = '{sub: 1'b0, sat: 1'b1};
         end
         default: begin
            alu_x = mul_q;
         end
      endcase
   end

   carpi_alu u_alu (
      .x     (alu_x),
      .y     (alu_y),
      .op    (alu_op),
      .limit (alu_limit),
      .result(alu_res)
   );

   // Error register also holds the rate target between its two steps.
   always_comb begin
      err_in       = err_ff;
      angle_int_in = angle_int_ff;
      rate_int_in  = rate_int_ff;
      case (state)
         carpi_pkg::ST_ERR:   err_in       = alu_res;
         carpi_pkg::ST_TGT:   err_in       = alu_res;
         carpi_pkg::ST_RERR:  err_in       = alu_res;
         carpi_pkg::ST_INT_A: angle_int_in = alu_res;
         carpi_pkg::ST_INT_R: rate_int_in  = alu_res;
         default:             err_in       = err_ff;
      endcase
   end

   // Output register: loads the drive when free, drops valid once the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if ((state == carpi_pkg::ST_DRV) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = alu_res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state, integrators and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff       <= 1'b0;
         angle_int_ff       <= '0;
         rate_int_ff        <= '0;
         command_scale_ff   <= carpi_pkg::RST_COMMAND_SCALE;
         rate_limit_ff      <= carpi_pkg::RST_RATE_LIMIT;
         angle_kp_ff        <= carpi_pkg::RST_ANGLE_KP;
         angle_ki_ff        <= carpi_pkg::RST_ANGLE_KI;
         angle_int_limit_ff <= carpi_pkg::RST_ANGLE_INT_LIMIT;
         rate_kp_ff         <= carpi_pkg::RST_RATE_KP;
         rate_ki_ff         <= carpi_pkg::RST_RATE_KI;
         rate_int_limit_ff  <= carpi_pkg::RST_RATE_INT_LIMIT;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         angle_int_ff <= angle_int_in;
         rate_int_ff  <= rate_int_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               carpi_pkg::CSR_COMMAND_SCALE:   command_scale_ff   <= csr_wdata;
               carpi_pkg::CSR_RATE_LIMIT:      rate_limit_ff      <= csr_wdata;
               carpi_pkg::CSR_ANGLE_KP:        angle_kp_ff        <= csr_wdata;
               carpi_pkg::CSR_ANGLE_KI:        angle_ki_ff        <= csr_wdata;
               carpi_pkg::CSR_ANGLE_INT_LIMIT: angle_int_limit_ff <= csr_wdata;
               carpi_pkg::CSR_RATE_KP:         rate_kp_ff         <= csr_wdata;
               carpi_pkg::CSR_RATE_KI:         rate_ki_ff         <= csr_wdata;
               carpi_pkg::CSR_RATE_INT_LIMIT:  rate_int_limit_ff  <= csr_wdata;
               default:                        rate_int_limit_ff  <= rate_int_limit_ff;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
      if (req_beat) begin
         stick_ff <= req_tdata[31:0];
         angle_ff <= req_tdata[63:32];
         rate_ff  <= req_tdata[95:64];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The angle integrator stays inside its limit after each update.
   assert property (@(posedge clock) disable iff (reset)
      (state == carpi_pkg::ST_INT_A) |=>
         (angle_int_ff <= $signed({1'b0, angle_int_limit_ff})) &&
         (angle_int_ff >= -$signed({1'b0, angle_int_limit_ff})))
      else $error("angle integrator outside its limit");

   // The rate integrator stays inside its limit after each update.
   assert property (@(posedge clock) disable iff (reset)
      (state == carpi_pkg::ST_INT_R) |=>
         (rate_int_ff <= $signed({1'b0, rate_int_limit_ff})) &&
         (rate_int_ff >= -$signed({1'b0, rate_int_limit_ff})))
      else $error("rate integrator outside its limit");

   // A result beat appears only out of the drive step.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && (state != carpi_pkg::ST_DRV)) |=> !rsp_valid_ff)
      else $error("result beat without a finished tick");

   // A taken request starts the sequence at the command product.
   assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state == carpi_pkg::ST_MUL_CMD))
      else $error("request beat did not start a tick");

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the cascaded angle/rate PI unit: stimulus, prediction and checks.
`default_nettype none

module tb_top;

   localparam int unsigned FRAC_BITS    = 8;
   localparam bit          RATE_ONLY    = 1'b0;
   localparam int          SETTLE_TICKS = 30;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          PRINT_LIMIT  = 100;
   localparam int unsigned WORD_W       = carpi_pkg::WORD_W;
   localparam int unsigned GAIN_W       = carpi_pkg::GAIN_W;
   localparam int unsigned INDEX_W      = carpi_pkg::INDEX_W;

   localparam logic [WORD_W-1:0] LEVEL_MAX = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] LEVEL_MIN = 32'h8000_0000;
   localparam logic [WORD_W-1:0] LEVEL_NEG = 32'hFFFF_FFFF;
   localparam logic [GAIN_W-1:0] GAIN_MAX  = 31'h7FFF_FFFF;
   localparam longint            WORD_MAX  = (64'sd1 <<< 31) - 64'sd1;
   localparam longint            WORD_MIN  = -(64'sd1 <<< 31);

   // One control tick as it travels on the request stream.
   typedef struct {
      logic signed [WORD_W-1:0] stick;
      logic signed [WORD_W-1:0] angle;
      logic signed [WORD_W-1:0] rate;
   } tick_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [95:0]         req_tdata  = '0;   // stick_command, measured_angle, measured_rate
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [31:0]         rsp_tdata;         // drive
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [INDEX_W-1:0]  csr_index  = '0;
   logic [GAIN_W-1:0]   csr_wdata  = '0;

   // Shadow copy of the register file and of both integrators.
   logic [GAIN_W-1:0] gain_shadow [8];
   longint            angle_acc;
   longint            rate_acc;

   logic [WORD_W-1:0] drive_expected [$];
   int                error_count = 0;
   int                cycle_count = 0;
   int                rsp_hold    = 0;
   bit                gaps_on     = 1'b1;

   cascaded_angle_rate_pi_unit #(
      .FRACTION_BITS  (FRAC_BITS),
      .RATE_ONLY_AXIS (RATE_ONLY)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Saturation to the signed 32-bit range.
   function automatic longint sat_word(longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   function automatic longint clamp_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // Fixed-point product, rounded toward minus infinity, then saturated.
   function automatic longint fixed_mul(longint a, longint b);
      longint p;
      p = a * b;
      return sat_word(p >>> FRAC_BITS);
   endfunction

   // One control tick of the cascade; updates both integrators, only the rate one when RATE_ONLY is set.
   function automatic logic [WORD_W-1:0] predict_drive(tick_type t);
      longint stick, angle, rate, scale;
      longint angle_err, target, rate_err, drive;
      stick = longint'(t.stick);
      angle = longint'(t.angle);
      rate  = longint'(t.rate);
      scale = longint'(gain_shadow[carpi_pkg::CSR_COMMAND_SCALE]);
      if (RATE_ONLY) begin
         target = fixed_mul(stick, scale);
      end else begin
         angle_err = sat_word(fixed_mul(scale, stick) - angle);
         angle_acc = clamp_sym(angle_acc +
            fixed_mul(angle_err, longint'(gain_shadow[carpi_pkg::CSR_ANGLE_KI])),
            longint'(gain_shadow[carpi_pkg::CSR_ANGLE_INT_LIMIT]));
         target = clamp_sym(angle_acc +
            fixed_mul(angle_err, longint'(gain_shadow[carpi_pkg::CSR_ANGLE_KP])),
            longint'(gain_shadow[carpi_pkg::CSR_RATE_LIMIT]));
      end
      rate_err = sat_word(target - rate);
      rate_acc = clamp_sym(rate_acc +
         fixed_mul(rate_err, longint'(gain_shadow[carpi_pkg::CSR_RATE_KI])),
         longint'(gain_shadow[carpi_pkg::CSR_RATE_INT_LIMIT]));
      drive = sat_word(rate_acc +
         fixed_mul(rate_err, longint'(gain_shadow[carpi_pkg::CSR_RATE_KP])));
      return drive[WORD_W-1:0];
   endfunction

   function automatic int draw_gap();
      return gaps_on ? $urandom_range(0, 6) : 0;
   endfunction

   // Input level: mostly near zero, sometimes full range or an extreme.
   function automatic logic [WORD_W-1:0] draw_level(int span);
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: begin
            case ($urandom_range(0, 4))
               0: return LEVEL_MAX;
               1: return LEVEL_MIN;
               2: return LEVEL_NEG;
               3: return 32'd1;
               default: return '0;
            endcase
         end
         1, 2: return $urandom();
         default: return $unsigned(int'($urandom_range(0, 2 * span)) - span);
      endcase
   endfunction

   // Register value: mostly moderate, sometimes zero, the maximum or full range.
   function automatic logic [GAIN_W-1:0] draw_setting(int unsigned span);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return GAIN_MAX;
         2: return GAIN_W'($urandom());
         default: return GAIN_W'($urandom_range(0, span));
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                  logic [WORD_W-1:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s: got %h, expected %h",
                  cycle_count, what, got, want);
   endtask

   // Sends one request beat and records its predicted drive once accepted.
   task automatic send_tick(logic [WORD_W-1:0] stick, logic [WORD_W-1:0] angle,
                            logic [WORD_W-1:0] rate);
      int       gap;
      tick_type t;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {rate, angle, stick};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      t.stick = stick;
      t.angle = angle;
      t.rate  = rate;
      drive_expected.push_back(predict_drive(t));
   endtask

   // Stops sending and waits until every pending drive beat has come back.
   task automatic wait_settled();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (drive_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_reg(logic [INDEX_W-1:0] index, logic [GAIN_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      gain_shadow[index] = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_all(logic [GAIN_W-1:0] value);
      for (int i = 0; i < 8; i++) write_reg(INDEX_W'(i), value);
   endtask

   // Reset values: zero command scale, so only the measurements matter.
   task automatic test_reset_values();
      send_tick('0, '0, '0);
      send_tick(LEVEL_MAX, LEVEL_MIN, '0);
      send_tick(LEVEL_MIN, LEVEL_MAX, LEVEL_MAX);
      send_tick(32'd256, LEVEL_NEG, LEVEL_MIN);
      wait_settled();
   endtask

   // Every register at its maximum, so extreme inputs drive products and sums into saturation.
   task automatic test_saturation();
      write_all(GAIN_MAX);
      send_tick(LEVEL_MAX, LEVEL_MIN, LEVEL_MIN);
      send_tick(LEVEL_MIN, LEVEL_MAX, LEVEL_MAX);
      send_tick(LEVEL_MAX, LEVEL_MAX, '0);
      send_tick(LEVEL_MIN, LEVEL_MIN, LEVEL_MAX);
      send_tick(LEVEL_NEG, 32'd1, LEVEL_NEG);
      send_tick('0, '0, '0);
      wait_settled();
   endtask

   // Integrators wound up, then their limits lowered: next tick must clamp them.
   task automatic test_limit_lowered();
      write_reg(carpi_pkg::CSR_COMMAND_SCALE, 31'd256);
      write_reg(carpi_pkg::CSR_ANGLE_KP, 31'd64);
      write_reg(carpi_pkg::CSR_ANGLE_KI, 31'd4096);
      write_reg(carpi_pkg::CSR_RATE_KP, 31'd256);
      write_reg(carpi_pkg::CSR_RATE_KI, 31'd4096);
      send_tick(32'd100000, '0, '0);
      send_tick(32'd100000, '0, 32'hFFFF_0000);
      send_tick(32'd100000, '0, '0);
      wait_settled();
      write_reg(carpi_pkg::CSR_ANGLE_INT_LIMIT, 31'd1000);
      write_reg(carpi_pkg::CSR_RATE_INT_LIMIT, 31'd1000);
      write_reg(carpi_pkg::CSR_RATE_LIMIT, 31'd5000);
      send_tick('0, '0, '0);
      send_tick('0, '0, '0);
      wait_settled();
      write_reg(carpi_pkg::CSR_ANGLE_INT_LIMIT, '0);
      write_reg(carpi_pkg::CSR_RATE_INT_LIMIT, '0);
      write_reg(carpi_pkg::CSR_RATE_LIMIT, '0);
      send_tick(32'd500, 32'd3, 32'hFFFF_FF00);
      send_tick(LEVEL_MIN, LEVEL_MAX, 32'd7);
      wait_settled();
   endtask

   // All registers zero: every gain and limit is zero, so the drive must be zero.
   task automatic test_all_zero();
      write_all('0);
      send_tick(LEVEL_MAX, LEVEL_MIN, LEVEL_MAX);
      send_tick(32'd1234, 32'd99, LEVEL_MIN);
      wait_settled();
   endtask

   // Random settings per phase with random ticks; gaps switch on and off in stretches.
   task automatic test_random();
      for (int phase = 0; phase < 6; phase++) begin
         write_reg(carpi_pkg::CSR_COMMAND_SCALE, draw_setting(4096));
         write_reg(carpi_pkg::CSR_RATE_LIMIT, draw_setting(1 << 20));
         write_reg(carpi_pkg::CSR_ANGLE_KP, draw_setting(1024));
         write_reg(carpi_pkg::CSR_ANGLE_KI, draw_setting(256));
         write_reg(carpi_pkg::CSR_ANGLE_INT_LIMIT, draw_setting(1 << 18));
         write_reg(carpi_pkg::CSR_RATE_KP, draw_setting(1024));
         write_reg(carpi_pkg::CSR_RATE_KI, draw_setting(256));
         write_reg(carpi_pkg::CSR_RATE_INT_LIMIT, draw_setting(1 << 18));
         for (int n = 0; n < 125; n++) begin
            if (n % 40 == 0) gaps_on = $urandom_range(0, 2) != 0;
            if (phase == 2 && n == 60) wait_settled();
            send_tick(draw_level(512), draw_level(1 << 14), draw_level(1 << 14));
         end
         wait_settled();
      end
      gaps_on = 1'b1;
   endtask

   // Result side: random stall before each beat, drawn when the previous one is taken.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Checks each drive beat against the oldest prediction; also guards the run length.
   initial begin
      logic [WORD_W-1:0] want;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
         end
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (drive_expected.size() == 0) begin
               report_mismatch("drive with nothing pending", rsp_tdata, 'x);
            end else begin
               want = drive_expected.pop_front();
               if (rsp_tdata !== want) report_mismatch("drive", rsp_tdata, want);
            end
            rsp_hold = draw_gap();
         end
      end
   end

   initial begin
      gain_shadow[carpi_pkg::CSR_COMMAND_SCALE]   = carpi_pkg::RST_COMMAND_SCALE;
      gain_shadow[carpi_pkg::CSR_RATE_LIMIT]      = carpi_pkg::RST_RATE_LIMIT;
      gain_shadow[carpi_pkg::CSR_ANGLE_KP]        = carpi_pkg::RST_ANGLE_KP;
      gain_shadow[carpi_pkg::CSR_ANGLE_KI]        = carpi_pkg::RST_ANGLE_KI;
      gain_shadow[carpi_pkg::CSR_ANGLE_INT_LIMIT] = carpi_pkg::RST_ANGLE_INT_LIMIT;
      gain_shadow[carpi_pkg::CSR_RATE_KP]         = carpi_pkg::RST_RATE_KP;
      gain_shadow[carpi_pkg::CSR_RATE_KI]         = carpi_pkg::RST_RATE_KI;
      gain_shadow[carpi_pkg::CSR_RATE_INT_LIMIT]  = carpi_pkg::RST_RATE_INT_LIMIT;
      angle_acc = 0;
      rate_acc  = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      test_reset_values();
      test_saturation();
      test_limit_lowered();
      test_all_zero();
      test_random();

      wait_settled();
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
